@@ rtl/srb_pkg.sv @@
// Package with the shared widths and defaults of the sequence reorder buffer.
package srb_pkg;

  localparam int SEQ_W        = 64;
  localparam int TAG_W        = 16;
  localparam int WINDOW_DEF   = 64;
  localparam int TAG_BITS_DEF = 16;
  localparam int IN_DATA_W    = SEQ_W + TAG_W;
  localparam int OUT_DATA_W   = TAG_W + SEQ_W;

endpackage

@@ rtl/srb_tag_ram.sv @@
// Tag store of the reorder ring: one write port and one registered read port.
module srb_tag_ram #(
  parameter int DEPTH = srb_pkg::WINDOW_DEF,
  parameter int WIDTH = srb_pkg::TAG_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  import srb_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sequence_reorder_buffer.sv @@
// Sequence reorder buffer: puts out-of-order frame tags back in sequence order.
//
// Each input beat carries a 64-bit frame sequence number and a buffer tag. The first beat
// after reset sets the expected head. Every beat writes its tag into ring slot (sequence mod
// WINDOW), overwriting an older tag there, and the block then delivers tags from the head
// slot onward until it meets an empty slot; the last delivery of such a run has out_tlast
// set. Each arrival goes from the idle state to an occupancy check of the head slot, which
// returns to idle at an empty slot; each delivered tag also passes through the registered
// read of the tag memory. Input is held off meanwhile, and output back-pressure stalls the
// occupancy check. Sequence numbers wrap modulo 2^64.
module sequence_reorder_buffer #(
  parameter int WINDOW   = srb_pkg::WINDOW_DEF,
  parameter int TAG_BITS = srb_pkg::TAG_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [srb_pkg::IN_DATA_W-1:0]  in_tdata,   // frame_seq[63:0], buffer_tag[79:64]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [srb_pkg::OUT_DATA_W-1:0] out_tdata,  // out_tag[15:0], out_seq[79:16]
  output logic                           out_tlast
);
  import srb_pkg::*;

  localparam int IW = $clog2(WINDOW);
  localparam int SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_READ
  } state_t;

  state_t            state_r;
  logic              head_known_r;
  logic [SEQ_W-1:0]  head_r;
  logic [WINDOW-1:0] full_r;
  logic              last_r;
  logic [SEQ_W-1:0]  seq_r;
  logic              out_tvalid_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic              out_tlast_r;

  logic              in_acc;
  logic [SEQ_W-1:0]  in_seq;
  logic [IW-1:0]     in_idx;
  logic [IW-1:0]     hidx;
  logic [IW-1:0]     hidx_inc;
  logic [SEQ_W-1:0]  head_inc;
  logic              out_free;
  logic              rd_en;
  logic [SW-1:0]     rd_data;
  logic [TAG_W-1:0]  rd_ext;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_seq    = in_tdata[SEQ_W-1:0];
  assign in_idx    = in_seq[IW-1:0];
  assign hidx      = head_r[IW-1:0];
  assign head_inc  = head_r + 64'd1;
  assign hidx_inc  = head_inc[IW-1:0];
  assign out_free  = !out_tvalid_r || out_tready;
  assign rd_en     = (state_r == ST_LOOK) && full_r[hidx] && out_free;

  always_comb begin
    rd_ext         = '0;
    rd_ext[SW-1:0] = rd_data;
  end

  srb_tag_ram #(
    .DEPTH (WINDOW),
    .WIDTH (SW)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (in_idx),
    .wr_data (in_tdata[SEQ_W +: SW]),
    .rd_en   (rd_en),
    .rd_addr (hidx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_known_r <= 1'b0;
      head_r       <= '0;
      full_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            full_r[in_idx] <= 1'b1;
            if (!head_known_r) begin
              head_r       <= in_seq;
              head_known_r <= 1'b1;
            end
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (!full_r[hidx]) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            full_r[hidx] <= 1'b0;
            seq_r        <= head_r;
            last_r       <= !full_r[hidx_inc];
            head_r       <= head_inc;
            state_r      <= ST_READ;
          end
        end
        ST_READ: begin
          out_tvalid_r <= 1'b1;
          out_tag_r    <= rd_ext;
          out_seq_r    <= seq_r;
          out_tlast_r  <= last_r;
          state_r      <= last_r ? ST_IDLE : ST_LOOK;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_seq_r, out_tag_r};
  assign out_tlast  = out_tlast_r;

`ifndef ASSERT_OFF
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_tvalid_r)
    else $error("tag read returned while the output register was occupied");

  a_slot_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> !full_r[$past(hidx)])
    else $error("delivered slot still marked full");

  a_first_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !head_known_r) |=> (head_known_r && head_r == $past(in_seq)))
    else $error("first arrival did not set the head");

  a_empty_head_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && !full_r[hidx]) |=> in_tready)
    else $error("input not reopened after an empty head slot");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for the sequence reorder buffer: directed and random frames against a predictor.
module testbench;
  import srb_pkg::*;

  localparam int WINDOW        = WINDOW_DEF;
  localparam int TAG_BITS      = TAG_BITS_DEF;
  localparam int ITEMS         = 330;
  localparam int CALM_ITEMS    = 40;
  localparam int MAX_RUNS      = 2;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int TAIL_CYCLES   = 150;
  localparam int DIR_ROWS      = 16;
  localparam logic [SEQ_W-1:0] SLOT_MASK = SEQ_W'(WINDOW - 1);
  localparam logic [31:0]      TAG_MASK  =
    (TAG_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TAG_BITS) - 1);

  typedef enum logic [1:0] {ROW_PRED, ROW_ONE, ROW_NONE} row_kind_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } delivery_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    row_kind_t        kind;
    logic [TAG_W-1:0] exp_tag;
    logic [SEQ_W-1:0] exp_seq;
  } frame_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  logic [SEQ_W-1:0] head_seq_q = '0;
  bit               head_known_q = 1'b0;
  bit               slot_full_q [WINDOW];
  logic [TAG_W-1:0] slot_tag_q [WINDOW];

  delivery_t pending_deliveries [$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        quiet_cycles = 0;
  bit        idle_on = 1'b1;

  frame_row_t directed_rows [DIR_ROWS] = '{
    '{64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, ROW_ONE,  16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{64'h0,                   16'h0000, ROW_ONE,  16'h0000, 64'h0},
    '{64'd3,                   16'h1234, ROW_NONE, 16'h0000, 64'h0},
    '{64'd2,                   16'h5678, ROW_NONE, 16'h0000, 64'h0},
    '{64'd1,                   16'hABCD, ROW_PRED, 16'h0000, 64'h0},
    '{64'd5,                   16'h1111, ROW_NONE, 16'h0000, 64'h0},
    '{64'd69,                  16'h2222, ROW_NONE, 16'h0000, 64'h0},
    '{64'd4,                   16'h3333, ROW_PRED, 16'h0000, 64'h0},
    '{64'd64006,               16'h8001, ROW_ONE,  16'h8001, 64'd6},
    '{64'hFFFF_FFFF_FFFF_FFC7, 16'h7FFE, ROW_ONE,  16'h7FFE, 64'd7},
    '{64'h8000_0000_0000_0008, 16'h0001, ROW_ONE,  16'h0001, 64'd8},
    '{64'h5555_5555_5555_5549, 16'hAAAA, ROW_ONE,  16'hAAAA, 64'd9},
    '{64'hAAAA_AAAA_AAAA_AA8A, 16'h5555, ROW_ONE,  16'h5555, 64'd10},
    '{64'd76,                  16'h0F0F, ROW_NONE, 16'h0000, 64'h0},
    '{64'd13,                  16'hF0F0, ROW_NONE, 16'h0000, 64'h0},
    '{64'd11,                  16'h00FF, ROW_PRED, 16'h0000, 64'h0}
  };

  sequence_reorder_buffer #(
    .WINDOW   (WINDOW),
    .TAG_BITS (TAG_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Writes the arriving tag into its slot and drains the in-order run from the head.
  task automatic reorder_arrival(input logic [SEQ_W-1:0] seq, input logic [TAG_W-1:0] tag,
                                 input row_kind_t kind, input delivery_t typed);
    delivery_t run [$];
    delivery_t d;
    int        idx;
    int        h;
    if (!head_known_q) begin
      head_seq_q   = seq;
      head_known_q = 1'b1;
    end
    idx = int'(seq & SLOT_MASK);
    slot_tag_q[idx]  = TAG_W'(32'(tag) & TAG_MASK);
    slot_full_q[idx] = 1'b1;
    while (run.size() < WINDOW) begin
      h = int'(head_seq_q & SLOT_MASK);
      if (!slot_full_q[h]) break;
      slot_full_q[h] = 1'b0;
      d.tag  = slot_tag_q[h];
      d.seq  = head_seq_q;
      d.last = 1'b0;
      run.push_back(d);
      head_seq_q = head_seq_q + 1'b1;
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    case (kind)
      ROW_PRED: begin
        foreach (run[i]) pending_deliveries.push_back(run[i]);
      end
      ROW_ONE: begin
        pending_deliveries.push_back(typed);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_frame(input logic [SEQ_W-1:0] seq, input logic [TAG_W-1:0] tag,
                            input row_kind_t kind, input delivery_t typed);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {tag, seq};
    do @(posedge clk); while (!in_tready);
    reorder_arrival(seq, tag, kind, typed);
    items_sent++;
    @(negedge clk);
  endtask

  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_deliveries
    delivery_t want;
    delivery_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.tag  = out_tdata[TAG_W-1:0];
      got.seq  = out_tdata[TAG_W +: SEQ_W];
      got.last = out_tlast;
      if (pending_deliveries.size() == 0) begin
        $display("%0t: unexpected beat tag=%h seq=%h last=%b", $time, got.tag, got.seq, got.last);
        mismatches++;
      end else begin
        want = pending_deliveries.pop_front();
        if (got.tag !== want.tag) begin
          $display("%0t: out_tag expected %h actual %h", $time, want.tag, got.tag);
          mismatches++;
        end
        if (got.seq !== want.seq) begin
          $display("%0t: out_seq expected %h actual %h", $time, want.seq, got.seq);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $display("%0t: out_tlast expected %b actual %b", $time, want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SEQ_W-1:0] burst [$];
    logic [SEQ_W-1:0] s;
    logic [SEQ_W-1:0] keep;
    int               n;
    int               k;
    int               pick;
    int               full_runs;
    bit               head_late;
    full_runs = 0;
    for (int i = 0; i < WINDOW; i++) begin
      slot_full_q[i] = 1'b0;
      slot_tag_q[i]  = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      send_frame(directed_rows[r].seq, directed_rows[r].tag, directed_rows[r].kind,
                 '{directed_rows[r].exp_tag, directed_rows[r].exp_seq, 1'b1});
    end

    // Mostly in-window bursts from the head in shuffled order, with gaps, repeats,
    // aliased high sequence bits and the odd frame anywhere in sequence space.
    while (items_sent < ITEMS) begin
      if (items_sent >= ITEMS - CALM_ITEMS) idle_on = 1'b0;
      burst.delete();
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        burst.push_back({$urandom, $urandom});
      end else begin
        head_late = (pick == 1 && full_runs < MAX_RUNS);
        n = head_late ? WINDOW : $urandom_range(1, 10);
        if (head_late) full_runs++;
        for (int j = 0; j < n; j++) burst.push_back(head_seq_q + SEQ_W'(j));
        if (head_late) keep = burst.pop_front();
        for (int j = burst.size() - 1; j > 0; j--) begin
          k        = $urandom_range(0, j);
          s        = burst[j];
          burst[j] = burst[k];
          burst[k] = s;
        end
        if (head_late) begin
          burst.push_back(keep);
        end else begin
          if (n > 1 && $urandom_range(0, 7) == 0) burst.delete($urandom_range(0, n - 1));
          if ($urandom_range(0, 7) == 0) begin
            burst.insert($urandom_range(0, burst.size()),
                         burst[$urandom_range(0, burst.size() - 1)]);
          end
        end
      end
      foreach (burst[j]) begin
        s = burst[j];
        if ($urandom_range(0, 3) == 0) s = ({$urandom, $urandom} & ~SLOT_MASK) | (s & SLOT_MASK);
        send_frame(s, TAG_W'($urandom), ROW_PRED, '0);
      end
    end
    in_tvalid = 1'b0;

    while (pending_deliveries.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_deliveries.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/srb_pkg.sv
rtl/srb_tag_ram.sv
rtl/sequence_reorder_buffer.sv
sim/testbench.sv
